/* hdl/zntc_pkg.sv */
// ----------------------------------------------------------------------------
// zntc_pkg
// Shared widths, fixed-point constants and item type for the zener
// temperature cubic check pipeline.
// ----------------------------------------------------------------------------
package zntc_pkg;

  // Field and datapath widths
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned HALF_W   = ACC_W / 2;
  localparam int unsigned CENTI_W  = 16;

  // Horner steps after the leading coefficient
  localparam int unsigned HSTEPS   = 3;

  // Long division of the product acc*raw by 10000, one 16-bit digit per step
  localparam int unsigned PROD_W   = ACC_W + RAW_W;
  localparam int unsigned DIG_W    = 16;
  localparam int unsigned NCHUNK   = PROD_W / DIG_W;
  localparam int unsigned REM_W    = 14;
  localparam int unsigned DIV_X_W  = REM_W + DIG_W;
  localparam int unsigned RECIP_W  = 31;
  localparam int unsigned RECIP_SHIFT = DIV_X_W + REM_W;

  // Divisor and its reciprocal: ceil(2^44 / 10000), exact for all x < 2^30
  localparam logic [REM_W-1:0]   VOLT_DIV   = 14'd10000;
  localparam logic [RECIP_W-1:0] VOLT_RECIP = 31'd1759218605;

  // Curve coefficients in tenths, magnitudes only
  localparam logic [ACC_W-1:0] CUBE_TENTHS = 64'd2257;
  localparam logic [ACC_W-1:0] QUAD_TENTHS = 64'd13106;
  localparam logic [ACC_W-1:0] LIN_TENTHS  = 64'd25948;
  localparam logic [ACC_W-1:0] OFS_TENTHS  = 64'd17678;

  // One item in flight between Horner steps
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [RAW_W-1:0]        raw;
  } item_t;

endpackage

/* hdl/zener_temperature_cubic_check.sv */
// ----------------------------------------------------------------------------
// zener_temperature_cubic_check
// Converts a 16-bit sensor reading (100 uV units) to temperature in
// hundredths of a degree C using T = -225.7v^3 + 1310.6v^2 - 2594.8v + 1767.8
// evaluated in signed fixed point with FRAC_BITS fraction bits, flags results
// at or below zero as invalid, saturates at 65535 and compares valid results
// with the over_temp_limit register (APB address 0, reset 6000). One sample
// is taken per clock while the pipeline is not held; each result passes
// through three Horner steps of 13 stages each (the five-digit division by
// 10000 dominates), a scaling stage and the output register. When the
// output is held, upstream bubbles still close up and new samples are taken
// until the last pipeline stage is full.
// ----------------------------------------------------------------------------
module zener_temperature_cubic_check #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [zntc_pkg::RAW_W-1:0]       raw_sample_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [zntc_pkg::CENTI_W-1:0]     temp_centi_o,
  output logic                             temp_valid_o,
  output logic                             over_temp_o,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import zntc_pkg::*;

  localparam logic [2:0]         ADDR_OVER_TEMP_LIMIT = 3'd0;
  localparam logic [CENTI_W-1:0] LIMIT_RST            = 16'd6000;

  // Coefficients rounded to nearest, ties away from zero
  localparam logic [ACC_W-1:0] COEF_A =
    ACC_W'(0) - (((CUBE_TENTHS << FRAC_BITS) + ACC_W'(5)) / ACC_W'(10));
  localparam logic [ACC_W-1:0] COEF_B =
    ((QUAD_TENTHS << FRAC_BITS) + ACC_W'(5)) / ACC_W'(10);
  localparam logic [ACC_W-1:0] COEF_C =
    ACC_W'(0) - (((LIN_TENTHS << FRAC_BITS) + ACC_W'(5)) / ACC_W'(10));
  localparam logic [ACC_W-1:0] COEF_D =
    ((OFS_TENTHS << FRAC_BITS) + ACC_W'(5)) / ACC_W'(10);
  localparam logic [ACC_W-1:0] COEF_STEP [HSTEPS] = '{COEF_B, COEF_C, COEF_D};

  logic                 adv;
  item_t                hs_item [HSTEPS+1];
  logic                 hs_v    [HSTEPS+1];

  logic                 scl_v_q;
  logic                 scl_pos_q;
  logic                 scl_pos_d;
  logic [ACC_W-1:0]     scl_val_q;
  logic [ACC_W-1:0]     scl_val_d;
  logic [ACC_W-1:0]     acc_u;

  logic [ACC_W-1:0]     whole;
  logic [CENTI_W-1:0]   centi;
  logic                 ok_d;

  logic                 out_valid_q;
  logic [CENTI_W-1:0]   temp_centi_q;
  logic [CENTI_W-1:0]   temp_centi_d;
  logic                 temp_valid_q;
  logic                 over_temp_q;
  logic                 over_temp_d;

  logic [CENTI_W-1:0]   limit_q;

  // Hold the pipeline only when the last stage is full and the result waits
  assign adv        = !(out_valid_q && !out_ready_i && scl_v_q);
  assign in_ready_o = adv;

  // Seed the Horner chain with the cubic coefficient
  assign hs_v[0]        = in_valid_i;
  assign hs_item[0].acc = COEF_A;
  assign hs_item[0].raw = raw_sample_i;

  for (genvar k = 0; k < HSTEPS; k++) begin : g_step
    zntc_horner_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (hs_v[k]),
      .item_i  (hs_item[k]),
      .coef_i  (COEF_STEP[k]),
      .valid_o (hs_v[k+1]),
      .item_o  (hs_item[k+1])
    );
  end

  // Scale by 100 (64 + 32 + 4) with 64-bit wrap, note the sign
  assign acc_u     = hs_item[HSTEPS].acc;
  assign scl_pos_d = !acc_u[ACC_W-1] && (acc_u != '0);
  assign scl_val_d = (acc_u << 6) + (acc_u << 5) + (acc_u << 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_v_q <= 1'b0;
    end else if (adv) begin
      scl_v_q <= hs_v[HSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scl_pos_q <= scl_pos_d;
      scl_val_q <= scl_val_d;
    end
  end

  // Drop fraction bits, saturate, compare with the limit
  always_comb begin
    whole        = scl_val_q >> FRAC_BITS;
    ok_d         = scl_pos_q && (whole != '0);
    centi        = (|whole[ACC_W-1:CENTI_W]) ? '1 : whole[CENTI_W-1:0];
    temp_centi_d = ok_d ? centi : '0;
    over_temp_d  = ok_d && (centi >= limit_q);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q <= scl_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      temp_centi_q <= temp_centi_d;
      temp_valid_q <= ok_d;
      over_temp_q  <= over_temp_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign temp_centi_o = temp_centi_q;
  assign temp_valid_o = temp_valid_q;
  assign over_temp_o  = over_temp_q;

  // Configuration register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_OVER_TEMP_LIMIT)) begin
      limit_q <= pwdata[CENTI_W-1:0];
    end
  end

  // Configuration register read
  always_comb begin
    case (paddr)
      ADDR_OVER_TEMP_LIMIT: prdata = 32'(limit_q);
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule

/* hdl/zntc_horner_step.sv */
// ----------------------------------------------------------------------------
// zntc_horner_step
// One Horner step acc' = trunc(acc * raw / 10000) + coef, pipelined over
// thirteen register stages: magnitude, partial products, five radix-2^16
// division digits of two stages each, and the signed coefficient add.
// ----------------------------------------------------------------------------
module zntc_horner_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  zntc_pkg::item_t                item_i,
  input  logic signed [zntc_pkg::ACC_W-1:0] coef_i,
  output logic                           valid_o,
  output zntc_pkg::item_t                item_o
);
  import zntc_pkg::*;

  typedef struct packed {
    logic               neg;
    logic [RAW_W-1:0]   raw;
    logic [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]   quo;
    logic [REM_W-1:0]   rem;
    logic [DIG_W-1:0]   dig;
  } div_t;

  // Magnitude stage
  logic             abs_v_q;
  logic             abs_neg_q;
  logic [ACC_W-1:0] abs_mag_q;
  logic [ACC_W-1:0] abs_mag_d;
  logic [RAW_W-1:0] abs_raw_q;
  logic [ACC_W-1:0] acc_u;

  // Product stage
  logic                      mul_v_q;
  div_t                      mul_q;
  div_t                      mul_d;
  logic [HALF_W+RAW_W-1:0]   mul_hi;
  logic [HALF_W+RAW_W-1:0]   mul_lo;

  // Division stages
  div_t dva_q [NCHUNK];
  div_t dvb_q [NCHUNK];
  logic va_q  [NCHUNK];
  logic vb_q  [NCHUNK];

  // Coefficient add stage
  logic             fin_v_q;
  item_t            fin_q;
  logic [ACC_W-1:0] sum_d;
  div_t             last;

  // Split the accumulator into sign and magnitude
  assign acc_u     = item_i.acc;
  assign abs_mag_d = item_i.acc[ACC_W-1] ? (ACC_W'(0) - acc_u) : acc_u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_v_q <= 1'b0;
    end else if (adv_i) begin
      abs_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      abs_neg_q <= item_i.acc[ACC_W-1];
      abs_mag_q <= abs_mag_d;
      abs_raw_q <= item_i.raw;
    end
  end

  // Form magnitude * raw from two 32x16 partial products
  always_comb begin
    mul_hi     = abs_mag_q[ACC_W-1:HALF_W] * abs_raw_q;
    mul_lo     = abs_mag_q[HALF_W-1:0] * abs_raw_q;
    mul_d      = '0;
    mul_d.neg  = abs_neg_q;
    mul_d.raw  = abs_raw_q;
    mul_d.prod = {mul_hi, HALF_W'(0)} + PROD_W'(mul_lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (adv_i) begin
      mul_v_q <= abs_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mul_q <= mul_d;
    end
  end

  // Long division by 10000, most significant digit first
  for (genvar k = 0; k < NCHUNK; k++) begin : g_chunk
    div_t                       src;
    logic                       src_v;
    logic [DIV_X_W-1:0]         x;
    logic [DIV_X_W+RECIP_W-1:0] xr;
    logic [DIG_W+REM_W-1:0]     dm;
    div_t                       a_d;
    div_t                       b_d;

    if (k == 0) begin : g_first
      assign src   = mul_q;
      assign src_v = mul_v_q;
    end else begin : g_next
      assign src   = dvb_q[k-1];
      assign src_v = vb_q[k-1];
    end

    // Estimate the digit with the reciprocal; it is exact for this range
    always_comb begin
      x       = {src.rem, src.prod[PROD_W-1-k*DIG_W -: DIG_W]};
      xr      = x * VOLT_RECIP;
      a_d     = src;
      a_d.rem = x[REM_W-1:0];
      a_d.dig = xr[RECIP_SHIFT +: DIG_W];
    end

    // Remainder fits in 14 bits, so only the low bits of digit*10000 matter
    always_comb begin
      dm      = dva_q[k].dig * VOLT_DIV;
      b_d     = dva_q[k];
      b_d.rem = dva_q[k].rem - dm[REM_W-1:0];
      b_d.quo = {dva_q[k].quo[ACC_W-DIG_W-1:0], dva_q[k].dig};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[k] <= 1'b0;
        vb_q[k] <= 1'b0;
      end else if (adv_i) begin
        va_q[k] <= src_v;
        vb_q[k] <= va_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dva_q[k] <= a_d;
        dvb_q[k] <= b_d;
      end
    end
  end

  // Restore the sign and add the next coefficient
  assign last  = dvb_q[NCHUNK-1];
  assign sum_d = last.neg ? (ACC_W'(coef_i) - last.quo) : (ACC_W'(coef_i) + last.quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (adv_i) begin
      fin_v_q <= vb_q[NCHUNK-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fin_q.acc <= sum_d;
      fin_q.raw <= last.raw;
    end
  end

  assign valid_o = fin_v_q;
  assign item_o  = fin_q;

endmodule

/* hdl/zntc_checker.sv */
// ----------------------------------------------------------------------------
// zntc_checker
// Port-level checks on the result channel of the temperature check block,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module zntc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] temp_centi_o,
  input logic        temp_valid_o,
  input logic        over_temp_o
);

  // Hold a waiting result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temp_centi_o)
      && $stable(temp_valid_o) && $stable(over_temp_o))
    else $error("result changed while waiting for transfer");

  // An invalid result carries no temperature and no alarm
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !temp_valid_o |-> temp_centi_o == 16'd0 && !over_temp_o)
    else $error("invalid result with nonzero fields");

  // The alarm only comes with a valid temperature
  a_over_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_temp_o |-> temp_valid_o)
    else $error("over-temperature flagged on invalid result");

  // A valid temperature is never zero after truncation
  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && temp_valid_o |-> temp_centi_o != 16'd0)
    else $error("valid result with zero temperature");

endmodule

bind zener_temperature_cubic_check zntc_checker u_zntc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .temp_centi_o (temp_centi_o),
  .temp_valid_o (temp_valid_o),
  .over_temp_o  (over_temp_o)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for zener_temperature_cubic_check. Drives sensor
// samples in random bursts, stalls the result side on changing patterns and
// checks every result against a fixed-point cubic curve predictor. Walks the
// over-temperature limit through several settings over the APB port.
// ----------------------------------------------------------------------------
module tb;

  import zntc_pkg::*;

  localparam int unsigned FRAC_BITS  = 32;
  localparam int          LATENCY    = 45;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          PHASE_LEN  = 150;
  localparam int          HOLD_LEN   = 300;
  localparam logic [15:0] LIMIT_RESET = 16'd6000;

  // Register map
  localparam logic [2:0] REG_OVER_TEMP_LIMIT = 3'd0;
  localparam logic [2:0] REG_PAST_END        = 3'd4;

  // Curve coefficients in tenths
  localparam int CUBE_TENTHS = -2257;
  localparam int QUAD_TENTHS = 13106;
  localparam int LIN_TENTHS  = -25948;
  localparam int OFS_TENTHS  = 17678;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic [CENTI_W-1:0] centi;
    logic               valid;
    logic               over;
  } temp_result_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    temp_result_t     want;
  } pending_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             typed;
    temp_result_t     want;
  } probe_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [RAW_W-1:0]   raw_sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CENTI_W-1:0] temp_centi_o;
  logic               temp_valid_o;
  logic               over_temp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pending_t    pending_temps [$];
  logic [15:0] limit_shadow;
  int          mismatches    = 0;
  int          cycle_count   = 0;
  int          burst_left    = 0;
  logic        hold_off_req  = 1'b0;

  // Directed samples; expectations typed only where obvious
  probe_row_t probe_table [0:7] = '{
    '{16'h0000, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},  // lowest reading, hottest, saturates
    '{16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},  // far below zero
    '{16'h8000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'hAAAA, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{16'h0001, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'd10000, 1'b0, '0},
    '{16'd20000, 1'b0, '0}
  };

  zener_temperature_cubic_check #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_sample_i(raw_sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .temp_centi_o(temp_centi_o),
    .temp_valid_o(temp_valid_o),
    .over_temp_o (over_temp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Free-running clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Coefficient in tenths to fixed point, nearest with ties away from zero
  function automatic logic signed [63:0] coef_fixed(input int tenths);
    logic [63:0] mag;
    mag = (tenths < 0) ? 64'(-tenths) : 64'(tenths);
    mag = ((mag << FRAC_BITS) + 64'd5) / 64'd10;
    return (tenths < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Exact x * raw / 10000, truncated toward zero
  function automatic logic signed [63:0] scale_by_volt(input logic signed [63:0] x,
                                                       input logic [RAW_W-1:0] raw);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag  = x[63] ? 64'(-x) : 64'(x);
    prod = {64'd0, mag} * {112'd0, raw};
    prod = prod / 128'd10000;
    return x[63] ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // Evaluate the curve in Horner form and apply the flags
  function automatic temp_result_t predict_temperature(input logic [RAW_W-1:0] raw);
    logic signed [63:0] acc;
    logic [63:0]        whole;
    temp_result_t       res;
    res = '0;
    acc = coef_fixed(CUBE_TENTHS);
    acc = scale_by_volt(acc, raw) + coef_fixed(QUAD_TENTHS);
    acc = scale_by_volt(acc, raw) + coef_fixed(LIN_TENTHS);
    acc = scale_by_volt(acc, raw) + coef_fixed(OFS_TENTHS);
    if (acc > 0) begin
      whole = (64'(acc) * 64'd100) >> FRAC_BITS;
      if (whole > 0) begin
        res.valid = 1'b1;
        res.centi = (whole > 64'hFFFF) ? 16'hFFFF : whole[15:0];
        res.over  = (res.centi >= limit_shadow);
      end
    end
    return res;
  endfunction

  // Locate the first reading whose temperature falls to a threshold
  function automatic int first_raw_at_or_below(input logic [CENTI_W-1:0] threshold);
    temp_result_t res;
    for (int r = 0; r < 65536; r++) begin
      res = predict_temperature(r[RAW_W-1:0]);
      if (res.centi <= threshold) return r;
    end
    return 65535;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // One APB access; prdata is taken in the access cycle
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one sample inside the current burst, open a new burst when due
  task automatic offer_sample(input logic [RAW_W-1:0] raw, input logic typed,
                              input temp_result_t fixed);
    int gap;
    pending_t entry;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    entry.raw  = raw;
    entry.want = typed ? fixed : predict_temperature(raw);
    pending_temps.push_back(entry);
  endtask

  // Stop offering and let every expected result come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: changing stall patterns plus one long hold-off on request
  initial begin : receiver
    stall_mode_e mode;
    int span;
    int hold_left;
    int tick;
    mode        = READY_ALWAYS;
    span        = 0;
    hold_left   = 0;
    tick        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_LEN;
      end
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS:   out_ready_i <= 1'b1;
          READY_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
          READY_MOSTLY:   out_ready_i <= ($urandom_range(0, 4) != 0);
          default:        out_ready_i <= ((tick % 3) != 0);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    pending_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_temps.size() == 0) begin
        report_mismatch("result with none pending, temp_centi", 32'(temp_centi_o), 32'd0);
      end else begin
        head = pending_temps.pop_front();
        if (temp_centi_o !== head.want.centi)
          report_mismatch($sformatf("temp_centi raw=%0d", head.raw), 32'(temp_centi_o),
                          32'(head.want.centi));
        if (temp_valid_o !== head.want.valid)
          report_mismatch($sformatf("temp_valid raw=%0d", head.raw), 32'(temp_valid_o),
                          32'(head.want.valid));
        if (over_temp_o !== head.want.over)
          report_mismatch($sformatf("over_temp raw=%0d", head.raw), 32'(over_temp_o),
                          32'(head.want.over));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] rd;
    logic [15:0] limits [6];
    int          edges [6];
    int          sat_edge;
    int          zero_edge;
    int          raw_int;
    int          pick;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_sample_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    limit_shadow = LIMIT_RESET;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Check the limit after reset
    apb_access(1'b0, REG_OVER_TEMP_LIMIT, 32'd0, rd);
    if (rd !== {16'd0, LIMIT_RESET})
      report_mismatch("reset over_temp_limit", rd, 32'(LIMIT_RESET));

    // Locate saturation, limit and zero crossings on the curve
    sat_edge  = first_raw_at_or_below(16'hFFFE);
    zero_edge = first_raw_at_or_below(16'h0000);
    edges = '{sat_edge - 1, sat_edge, 0, 0, zero_edge - 1, zero_edge};
    edges[3] = first_raw_at_or_below(LIMIT_RESET - 16'd1);
    edges[2] = edges[3] - 1;

    // Directed part
    for (int i = 0; i < 8; i++)
      offer_sample(probe_table[i].raw, probe_table[i].typed, probe_table[i].want);
    foreach (edges[i])
      offer_sample(edges[i][RAW_W-1:0], 1'b0, '0);

    // Random part over several limit settings, extremes included
    limits = '{16'd0, 16'hFFFF, 16'($urandom_range(1000, 20000)), 16'd1,
               16'($urandom_range(0, 65535)), 16'd12000};
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      apb_access(1'b1, REG_OVER_TEMP_LIMIT, {16'($urandom), limits[phase]}, rd);
      limit_shadow = limits[phase];
      if (phase == 0) begin
        // Write past the register list; it must not land
        apb_access(1'b1, REG_PAST_END, 32'h0000_1234, rd);
      end
      apb_access(1'b0, REG_OVER_TEMP_LIMIT, 32'd0, rd);
      if (rd !== {16'd0, limit_shadow})
        report_mismatch("over_temp_limit readback", rd, 32'(limit_shadow));
      if (phase == 2) hold_off_req = 1'b1;

      repeat (PHASE_LEN) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          raw_int = $urandom_range(0, 23000);
        end else if (pick < 8) begin
          raw_int = $urandom_range(0, 65535);
        end else if (pick == 8) begin
          raw_int = zero_edge + $urandom_range(0, 80) - 40;
        end else begin
          raw_int = sat_edge + $urandom_range(0, 4000) - 200;
        end
        if (raw_int < 0) raw_int = 0;
        if (raw_int > 65535) raw_int = 65535;
        offer_sample(raw_int[RAW_W-1:0], 1'b0, '0);
      end
    end

    // Wind down
    drain_results();
    repeat (LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
